/* rtl/assert_macros.svh */
// Assertion helpers shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Invariant that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   `ASSERT_PROP(label, clk, rst, (expr))

`endif

/* rtl/swmf_pkg.sv */
package swmf_pkg;

   localparam int WINDOW_DEFAULT = 15;
   localparam int SAMPLE_W       = 16;
   localparam int FILL_W         = 4;
   localparam int AGE_W          = 4;

   // Controller to datapath commands for the steps of an item.
   typedef struct packed {
      logic load;
      logic age;
      logic scan_clr;
      logic scan_step;
      logic replace;
      logic remove;
      logic insert;
      logic result;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic full;
      logic scan_last;
   } status_type;

endpackage

/* rtl/sliding_window_median_filter.sv */
// Running median over the last WINDOW unsigned 16-bit samples. Each req_ transfer adds one
// sample (req_restart empties the window first) and yields exactly one rsp_ transfer with the
// median of the held samples, taken as the element at index count/2 in ascending order (the
// upper middle for an even count), and the fill count, which is masked to 4 bits. While the
// window is still filling an item steps through accept, age, insert and result; once it is
// full, an age scan that walks the entries one per cycle to find the oldest one to replace
// comes before replace, remove, insert and result. A new item is accepted while the
// previous result still waits in the output register. There is no start-up clearing pass.
module sliding_window_median_filter #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [swmf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swmf_pkg::SAMPLE_W-1:0] rsp_median,
   output logic [swmf_pkg::FILL_W-1:0]   rsp_fill_count
);
   import swmf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: accept, age, then (full window only) oldest scan, replace, remove; then insert, result.
   swmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Window store, age array, sorted copy and the output register.
   swmf_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .req_restart    (req_restart),
      .rsp_median     (rsp_median),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

/* rtl/swmf_ctrl.sv */
`include "assert_macros.svh"

module swmf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output swmf_pkg::cmd_type    cmd,
   input  swmf_pkg::status_type status
);
   import swmf_pkg::*;

   typedef enum logic [6:0] {
      IDLE    = 7'b0000001,
      AGE     = 7'b0000010,
      SCAN    = 7'b0000100,
      REPLACE = 7'b0001000,
      REMOVE  = 7'b0010000,
      INSERT  = 7'b0100000,
      DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = AGE;
            end
         end
         AGE: begin
            cmd.age      = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in     = status.full ? SCAN : INSERT;
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = REPLACE;
            end
         end
         REPLACE: begin
            cmd.replace = 1'b1;
            state_in    = REMOVE;
         end
         REMOVE: begin
            cmd.remove = 1'b1;
            state_in   = INSERT;
         end
         INSERT: begin
            cmd.insert = 1'b1;
            state_in   = DONE;
         end
         DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_PROP(a_accept_starts_age, clock, reset, (req_valid && req_ready) |=> (state_ff == AGE))
   `ASSERT_PROP(a_result_raises_valid, clock, reset, cmd.result |=> rsp_valid)

endmodule

/* rtl/swmf_datapath.sv */
`include "assert_macros.svh"

module swmf_datapath #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swmf_pkg::cmd_type             cmd,
   output swmf_pkg::status_type          status,
   input  logic [swmf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_restart,
   output logic [swmf_pkg::SAMPLE_W-1:0] rsp_median,
   output logic [swmf_pkg::FILL_W-1:0]   rsp_fill_count
);
   import swmf_pkg::*;

   localparam int CW = $clog2(WINDOW + 1);
   localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW);
   localparam logic [CW-1:0] LESS_ONE   = CW'(WINDOW - 1);
   localparam logic [IW-1:0] LAST_IDX   = IW'(WINDOW - 1);

   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] old_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [SAMPLE_W-1:0] value_ff  [WINDOW];
   logic [AGE_W-1:0]    age_ff    [WINDOW];
   logic [AGE_W-1:0]    age_in    [WINDOW];
   logic [SAMPLE_W-1:0] sorted_ff [WINDOW];
   logic [SAMPLE_W-1:0] sorted_in [WINDOW];
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       pick_ff, pick_in;
   logic [AGE_W-1:0]    best_ff, best_in;
   logic [SAMPLE_W-1:0] median_ff;
   logic [FILL_W-1:0]   fill_ff;

   logic                full;
   logic [CW-1:0]       ins_count;
   logic [CW-1:0]       half;
   logic [WINDOW-1:0]   ge_old;
   logic [WINDOW-1:0]   gt_new;

   assign full      = (count_ff == FULL_COUNT);
   assign ins_count = full ? LESS_ONE : count_ff;
   assign half      = count_ff >> 1;

   assign status.full      = full;
   assign status.scan_last = (idx_ff == LAST_IDX);

   // fill count: clear on restart, grow on append
   always_comb begin
      count_in = count_ff;
      if (cmd.load && req_restart) begin
         count_in = '0;
      end
      if (cmd.insert && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   // ages: clear on restart, advance held entries (saturating), zero the new entry
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         age_in[i] = age_ff[i];
         if (cmd.load && req_restart) begin
            age_in[i] = '0;
         end
         if (cmd.age) begin
            if (CW'(i) < count_ff) begin
               if (age_ff[i] != '1) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end else if (CW'(i) == count_ff) begin
               age_in[i] = '0;
            end
         end
         if (cmd.replace && (IW'(i) == pick_ff)) begin
            age_in[i] = '0;
         end
      end
   end

   // oldest-entry scan, one entry per cycle; strict compare keeps lowest index on ties
   always_comb begin
      idx_in  = idx_ff;
      pick_in = pick_ff;
      best_in = best_ff;
      if (cmd.scan_clr) begin
         idx_in  = '0;
         pick_in = '0;
         best_in = '0;
      end
      if (cmd.scan_step) begin
         if (age_ff[idx_ff] > best_ff) begin
            best_in = age_ff[idx_ff];
            pick_in = idx_ff;
         end
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end
   end

   // sorted copy: drop the replaced value, then insert the new sample
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         ge_old[i] = (sorted_ff[i] >= old_ff);
         gt_new[i] = (CW'(i) >= ins_count) || (sorted_ff[i] > sample_ff);
      end
      for (int i = 0; i < WINDOW; i++) begin
         sorted_in[i] = sorted_ff[i];
         if (cmd.remove) begin
            if ((i < WINDOW - 1) && ge_old[i]) begin
               sorted_in[i] = sorted_ff[(i + 1) % WINDOW];
            end
         end
         if (cmd.insert) begin
            if ((i > 0) && gt_new[(i + WINDOW - 1) % WINDOW]) begin
               sorted_in[i] = sorted_ff[(i + WINDOW - 1) % WINDOW];
            end else if (gt_new[i]) begin
               sorted_in[i] = sample_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < WINDOW; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pick_ff <= pick_in;
      best_ff <= best_in;
      for (int i = 0; i < WINDOW; i++) begin
         sorted_ff[i] <= sorted_in[i];
      end
      if (cmd.load) begin
         sample_ff <= req_sample;
      end
      if (cmd.age && !full) begin
         value_ff[count_ff[IW-1:0]] <= sample_ff;
      end
      if (cmd.replace) begin
         old_ff            <= value_ff[pick_ff];
         value_ff[pick_ff] <= sample_ff;
      end
      if (cmd.result) begin
         median_ff <= sorted_ff[half[IW-1:0]];
         fill_ff   <= FILL_W'(count_ff);
      end
   end

   assign rsp_median     = median_ff;
   assign rsp_fill_count = fill_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_COUNT)
   `ASSERT_PROP(a_scan_only_full, clock, reset, cmd.scan_step |-> full)
   `ASSERT_PROP(a_result_nonempty, clock, reset, cmd.result |-> (count_ff != '0))

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import swmf_pkg::*;

   localparam int WIN        = WINDOW_DEFAULT;
   localparam int AGE_MAX    = 15;
   localparam int CYCLE_CAP  = 400000;
   localparam int HOLD_LEN   = 500;
   localparam int HOLD_AFTER = 250;
   localparam int RANDOM_ITEMS = 800;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                restart;
   } sample_item_type;

   typedef struct {
      logic [SAMPLE_W-1:0] median;
      logic [FILL_W-1:0]   fill;
   } median_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample  = '0;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [SAMPLE_W-1:0] rsp_median;
   logic [FILL_W-1:0]   rsp_fill_count;

   sliding_window_median_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_median     (rsp_median),
      .rsp_fill_count (rsp_fill_count)
   );

   // Sample backlog and the medians the window should produce, oldest first.
   sample_item_type   sample_backlog[$];
   median_result_type median_expected_q[$];

   // Shadow copy of the window: held values, their ages and the fill level.
   logic [SAMPLE_W-1:0] shadow_vals[WIN];
   logic [AGE_W-1:0]    shadow_age[WIN];
   int                  shadow_held = 0;

   int total_items      = 0;
   int accepted_count   = 0;
   int restart_count    = 0;
   int replace_count    = 0;
   int results_seen     = 0;
   int error_count      = 0;
   int cycle_count      = 0;
   int req_gap_left     = 0;
   int rsp_stall_left   = 0;
   int rsp_stall_pick   = 0;
   int hold_left        = 0;
   int hold_cycles      = 0;
   logic hold_done      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Empty the window on a restart, age the held entries, add the sample (replacing the oldest
   // entry once the window is full), then queue the median of what is held.
   task automatic add_sample_to_window(input logic [SAMPLE_W-1:0] smp, input logic rst);
      logic [SAMPLE_W-1:0] sorted[WIN];
      logic [SAMPLE_W-1:0] v;
      logic [AGE_W-1:0]    oldest;
      median_result_type   res;
      int                  i, j, pick;
      if (rst) begin
         shadow_held = 0;
         foreach (shadow_age[k]) shadow_age[k] = '0;
         restart_count++;
      end
      for (i = 0; i < shadow_held; i++)
         if (shadow_age[i] < AGE_MAX) shadow_age[i] = shadow_age[i] + 1'b1;
      if (shadow_held < WIN) begin
         shadow_vals[shadow_held] = smp;
         shadow_age[shadow_held]  = '0;
         shadow_held++;
      end else begin
         // oldest entry wins, lowest index on a tie
         pick   = 0;
         oldest = shadow_age[0];
         for (i = 1; i < WIN; i++)
            if (shadow_age[i] > oldest) begin
               oldest = shadow_age[i];
               pick   = i;
            end
         shadow_vals[pick] = smp;
         shadow_age[pick]  = '0;
         replace_count++;
      end
      // insertion sort of the held values, ascending
      for (i = 0; i < shadow_held; i++) begin
         v = shadow_vals[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      res.median = sorted[shadow_held / 2];
      res.fill   = FILL_W'(shadow_held);
      median_expected_q.push_back(res);
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_idle();
      int r;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int flavor, input int idx);
      case (flavor)
         0:       return SAMPLE_W'($urandom_range(7, 0));
         1:       return ($urandom_range(1, 0) != 0) ? SAMPLE_W'($urandom_range(3, 0))
                                                      : SAMPLE_W'($urandom_range(65535, 65532));
         2:       return SAMPLE_W'(idx * 1021);
         default: return SAMPLE_W'($urandom_range(65535, 0));
      endcase
   endfunction

   // Fill the backlog: a directed opening, then runs of random samples.
   initial begin
      sample_item_type it;
      logic [SAMPLE_W-1:0] opening[20];
      logic                opening_rst[20];
      int n, run_len, flavor, k;
      opening = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF, 16'h8000,
                  16'h8000, 16'h0000, 16'hFFFF, 16'h1234, 16'hAAAA, 16'h5555, 16'h0000,
                  16'hFFFF, 16'h00FF, 16'hFF00, 16'h4321, 16'h0000, 16'hFFFF};
      foreach (opening_rst[i]) opening_rst[i] = 1'b0;
      // restart on an empty window, on a full one, and twice in a row
      opening_rst[0]  = 1'b1;
      opening_rst[17] = 1'b1;
      opening_rst[18] = 1'b1;
      foreach (opening[i]) begin
         it.sample  = opening[i];
         it.restart = opening_rst[i];
         sample_backlog.push_back(it);
      end
      n = 0;
      while (n < RANDOM_ITEMS) begin
         // long runs keep the window full so the oldest entry keeps rotating out
         run_len = ($urandom_range(3, 0) == 0) ? $urandom_range(14, 1)
                                               : $urandom_range(70, 16);
         flavor  = $urandom_range(5, 0);
         for (k = 0; k < run_len && n < RANDOM_ITEMS; k++) begin
            it.sample  = pick_sample(flavor, k);
            it.restart = (k == 0) ? ($urandom_range(3, 0) != 0)
                                  : ($urandom_range(59, 0) == 0);
            sample_backlog.push_back(it);
            n++;
         end
      end
      total_items = sample_backlog.size();
   end

   // Driver: present the next sample, hold it until the transfer, then idle
   // for the gap chosen with it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            add_sample_to_window(req_sample, req_restart);
            accepted_count <= accepted_count + 1;
         end
         if (req_valid && !req_ready) begin
            // hold the payload until it is taken
         end else if (req_gap_left > 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (sample_backlog.size() > 0) begin
            req_valid    <= 1'b1;
            req_sample   <= sample_backlog[0].sample;
            req_restart  <= sample_backlog[0].restart;
            void'(sample_backlog.pop_front());
            // every fourth stretch of 50 items goes back to back
            req_gap_left <= ((accepted_count / 50) % 4 == 2) ? 0 : pick_idle();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver ready: random stalls, quiet stretches with none, and one long
   // hold-off that backs the filter up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready   <= 1'b0;
         hold_left   <= hold_left - 1;
         hold_cycles <= hold_cycles + 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_LEN - 1;
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else if (rsp_stall_left > 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_stall_pick = ((cycle_count / 700) % 4 == 1) ? 0 : pick_idle();
         rsp_ready      <= (rsp_stall_pick == 0);
         rsp_stall_left <= (rsp_stall_pick > 0) ? rsp_stall_pick - 1 : 0;
      end
   end

   // Monitor: compare each result transfer with the oldest expected median.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (median_expected_q.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < REPORT_MAX)
               $display("unexpected result: median=%h fill=%0d", rsp_median, rsp_fill_count);
         end else begin
            if (rsp_median !== median_expected_q[0].median ||
                rsp_fill_count !== median_expected_q[0].fill) begin
               error_count <= error_count + 1;
               if (error_count < REPORT_MAX)
                  $display("result %0d mismatch: median exp %h got %h, fill exp %0d got %0d",
                           results_seen, median_expected_q[0].median, rsp_median,
                           median_expected_q[0].fill, rsp_fill_count);
            end
            void'(median_expected_q.pop_front());
         end
      end
   end

   // Watchdog: drop the run if it overruns the cycle cap.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d of %0d samples taken",
                  cycle_count, accepted_count, total_items);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (total_items == 0 || accepted_count < total_items ||
             median_expected_q.size() != 0)
         @(posedge clock);
      // allow for a stray extra result from the last item
      repeat (60) @(posedge clock);
      if (median_expected_q.size() != 0) begin
         $display("%0d expected results never arrived", median_expected_q.size());
         error_count = error_count + median_expected_q.size();
      end
      $display("Filtered %0d samples (%0d restarts, %0d oldest-entry replacements);",
               accepted_count, restart_count, replace_count);
      $display("checked %0d medians, receiver held off %0d cycles, %0d mismatches.",
               results_seen, hold_cycles, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
